// ===== rtl/core/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Holds request codes, status codes, controller states and the payload structs.
// No dependencies; double_ended_queue and deq_checker in rtl/core use this package.
package deq_pkg;

    // Default number of entries in the ring buffer.
    localparam int DEQ_CAPACITY = 1024;

    // Fixed payload field widths.
    localparam int REQ_W    = 4;
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Request codes.
    localparam logic [REQ_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [REQ_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [REQ_W-1:0] OP_POP_BACK   = 4'd2;
    localparam logic [REQ_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [REQ_W-1:0] OP_READ_AT    = 4'd4;
    localparam logic [REQ_W-1:0] OP_READ_FRONT = 4'd5;
    localparam logic [REQ_W-1:0] OP_READ_BACK  = 4'd6;
    localparam logic [REQ_W-1:0] OP_CLEAR      = 4'd7;
    localparam logic [REQ_W-1:0] OP_WRITE_AT   = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_READ
    } deq_state_t;

    // One request transfer.
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] value_in;
        logic [INDEX_W-1:0] index_in;
    } deq_req_t;

    // One result transfer.
    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } deq_rsp_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Parameters set the word width and the depth; no package dependencies.
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable; the read data is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/deq_divider.sv =====
// Iterative restoring remainder unit: dividend modulo divisor, one bit a cycle.
// Used to reduce a queue position modulo the entry count; no package dependencies.
module deq_divider #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg,  dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg,  dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg,  rem_next;
    logic [DIVISOR_W:0]    trial;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = LAST_STEP;
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Double-ended queue of 64-bit words kept in a ring buffer RAM (top level).
// Push, pop and clear finish in the execute state; front/back reads add a RAM read state.
// Read_at and write_at wait on the 16-step remainder unit to reduce the index modulo the count.
// One request is in flight at a time; busy is high until its result strobe.
// Reset clears the head position and count; the entry RAM is not cleared.
// Depends on deq_pkg, deq_ram and deq_divider.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_req_t req,
    output logic              done,
    output deq_pkg::deq_rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OUT_CW = deq_pkg::COUNT_W;
    localparam int VW = deq_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    deq_pkg::deq_state_t state_reg, state_next;
    deq_pkg::deq_req_t   req_reg,   req_next;
    deq_pkg::deq_rsp_t   rsp_reg,   rsp_next;
    logic                done_reg,  done_next;
    logic [AW-1:0]       head_reg,  head_next;
    logic [CW-1:0]       count_reg, count_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [VW-1:0] mem_wdata;
    logic [VW-1:0] mem_rdata;

    logic          div_start;
    logic [CW-1:0] div_divisor;
    logic          div_done;
    logic [CW-1:0] div_rem;

    logic [AW-1:0] slot_off;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_prev;

    // Entry storage.
    deq_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Position modulo count for indexed access.
    deq_divider #(
        .DIVIDEND_W (deq_pkg::INDEX_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req_reg.index_in),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
            done_reg  <= 1'b0;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Request and result holding registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Ring slot of the front entry plus an offset, wrapped at capacity.
    always_comb
    begin
        slot_sum = {1'b0, head_reg} + {1'b0, slot_off};
        if (slot_sum >= CAP_SUM)
        begin
            slot = AW'(slot_sum - CAP_SUM);
        end
        else
        begin
            slot = slot_sum[AW-1:0];
        end
        head_prev = (head_reg == '0) ? LAST_SLOT : AW'(head_reg - 1'b1);
    end

    // Offset into the ring for the current step.
    always_comb
    begin
        slot_off = '0;
        if (state_reg == deq_pkg::S_DIV)
        begin
            slot_off = AW'(div_rem);
        end
        else
        begin
            case (req_reg.req_type)
                deq_pkg::OP_PUSH_BACK: slot_off = AW'(count_reg);
                deq_pkg::OP_POP_FRONT: slot_off = AW'(1);
                deq_pkg::OP_READ_BACK: slot_off = AW'(count_reg - 1'b1);
                default:               slot_off = '0;
            endcase
        end
    end

    // Next state, queue pointers, RAM access and result.
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        head_next   = head_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_addr    = slot;
        mem_wdata   = req_reg.value_in;
        div_start   = 1'b0;
        div_divisor = count_reg;

        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = deq_pkg::S_EXEC;
                end
            end

            deq_pkg::S_EXEC:
            begin
                rsp_next.value_out = '0;
                rsp_next.status    = deq_pkg::ST_OK;
                state_next         = deq_pkg::S_IDLE;
                done_next          = 1'b1;
                unique case (req_reg.req_type) inside
                    deq_pkg::OP_PUSH_BACK:
                    begin
                        if (count_reg == CAP_COUNT)
                        begin
                            rsp_next.status = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    deq_pkg::OP_PUSH_FRONT:
                    begin
                        if (count_reg == CAP_COUNT)
                        begin
                            rsp_next.status = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_addr   = head_prev;
                            head_next  = head_prev;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            if (count_reg == CW'(1))
                            begin
                                head_next = '0;
                            end
                            else if (req_reg.req_type == deq_pkg::OP_POP_FRONT)
                            begin
                                head_next = slot;
                            end
                        end
                    end
                    deq_pkg::OP_READ_FRONT, deq_pkg::OP_READ_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = deq_pkg::S_READ;
                            done_next  = 1'b0;
                        end
                    end
                    deq_pkg::OP_READ_AT, deq_pkg::OP_WRITE_AT:
                    begin
                        // An empty queue first receives a zero word at the head.
                        if (count_reg == '0)
                        begin
                            mem_we      = 1'b1;
                            mem_addr    = head_reg;
                            mem_wdata   = '0;
                            count_next  = CW'(1);
                            div_divisor = CW'(1);
                        end
                        div_start  = 1'b1;
                        state_next = deq_pkg::S_DIV;
                        done_next  = 1'b0;
                    end
                    deq_pkg::OP_CLEAR:
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        // Unused codes leave the queue as it is.
                    end
                endcase
            end

            deq_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    if (req_reg.req_type == deq_pkg::OP_WRITE_AT)
                    begin
                        mem_we     = 1'b1;
                        state_next = deq_pkg::S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = deq_pkg::S_READ;
                    end
                end
            end

            deq_pkg::S_READ:
            begin
                rsp_next.value_out = mem_rdata;
                rsp_next.status    = deq_pkg::ST_OK;
                state_next         = deq_pkg::S_IDLE;
                done_next          = 1'b1;
            end

            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase

        rsp_next.count    = OUT_CW'(count_next);
        rsp_next.is_empty = (count_next == '0);
    end

    assign busy = (state_reg != deq_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/core/deq_checker.sv =====
// Port-level checks for double_ended_queue, attached by the bind at the end.
// Depends on deq_pkg for the result struct.
module deq_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input deq_pkg::deq_rsp_t rsp
);

    // An accepted request keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    // A result is shown only as the block becomes free again.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a request");

    // Two results never follow in consecutive cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // The empty flag agrees with the reported count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == deq_pkg::ST_OK || rsp.status == deq_pkg::ST_FULL
                  || rsp.status == deq_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind double_ended_queue deq_port_checks u_deq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ===== tb/sv/deq_checker.sv =====
// Result checker for the double-ended queue testbench.
// Watches request and result transfers, predicts every result and compares it field by field.
// Depends on deq_pkg; instantiated by tb beside the block under test.
module deq_checker #(
    parameter int CAPACITY = deq_pkg::DEQ_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  deq_pkg::deq_req_t req,
    input  logic              done,
    input  deq_pkg::deq_rsp_t rsp,
    output int                errors,
    output int                outstanding,
    output int                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the ring buffer, its front position and its fill level.
    logic [deq_pkg::VALUE_W-1:0] ring_word [CAPACITY];
    int unsigned                 front_pos;
    int unsigned                 held;

    // Results predicted for accepted requests, oldest first.
    deq_pkg::deq_rsp_t pending_rsp [$];

    // Apply one request to the shadow state and return the result it must produce.
    function automatic deq_pkg::deq_rsp_t apply_request(input deq_pkg::deq_req_t r);
        deq_pkg::deq_rsp_t o;
        int unsigned       slot;
        o = '0;
        o.status = deq_pkg::ST_OK;
        case (r.req_type)
            deq_pkg::OP_PUSH_BACK:
            begin
                if (held >= CAPACITY)
                    o.status = deq_pkg::ST_FULL;
                else
                begin
                    ring_word[(front_pos + held) % CAPACITY] = r.value_in;
                    held++;
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (held >= CAPACITY)
                    o.status = deq_pkg::ST_FULL;
                else
                begin
                    front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
                    ring_word[front_pos] = r.value_in;
                    held++;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (held == 0)
                    o.status = deq_pkg::ST_EMPTY;
                else
                begin
                    held--;
                    if (held == 0)
                        front_pos = 0;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (held == 0)
                    o.status = deq_pkg::ST_EMPTY;
                else
                begin
                    front_pos = (front_pos + 1) % CAPACITY;
                    held--;
                    if (held == 0)
                        front_pos = 0;
                end
            end
            deq_pkg::OP_READ_AT, deq_pkg::OP_WRITE_AT:
            begin
                // An empty queue first gets a zero word, which the index then selects.
                if (held == 0)
                begin
                    ring_word[front_pos] = '0;
                    held = 1;
                end
                slot = (front_pos + r.index_in % held) % CAPACITY;
                if (r.req_type == deq_pkg::OP_READ_AT)
                    o.value_out = ring_word[slot];
                else
                    ring_word[slot] = r.value_in;
            end
            deq_pkg::OP_READ_FRONT:
            begin
                if (held == 0)
                    o.status = deq_pkg::ST_EMPTY;
                else
                    o.value_out = ring_word[front_pos];
            end
            deq_pkg::OP_READ_BACK:
            begin
                if (held == 0)
                    o.status = deq_pkg::ST_EMPTY;
                else
                    o.value_out = ring_word[(front_pos + held - 1) % CAPACITY];
            end
            deq_pkg::OP_CLEAR:
            begin
                held = 0;
                front_pos = 0;
            end
            default:
            begin
                // Unused request codes leave the queue alone.
            end
        endcase
        o.count = deq_pkg::COUNT_W'(held);
        o.is_empty = (held == 0);
        return o;
    endfunction

    // Compare each result transfer with the oldest prediction, then predict new requests.
    always @(posedge clk or negedge rst_n)
    begin
        deq_pkg::deq_rsp_t want;
        if (!rst_n)
        begin
            front_pos = 0;
            held = 0;
            pending_rsp.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_rsp[0];
                    pending_rsp.delete(0);
                    checked++;
                    if (rsp.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, actual %h",
                               want.value_out, rsp.value_out);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, rsp.count);
                        errors++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, rsp.is_empty);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                pending_rsp.insert(pending_rsp.size(), apply_request(req));
        end
        outstanding = pending_rsp.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the double-ended queue testbench: clock, reset, stimulus, watchdog and verdict.
// Sends directed and random requests; deq_checker predicts and compares the results.
// Depends on deq_pkg, deq_checker and the double_ended_queue RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = deq_pkg::DEQ_CAPACITY;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 150;
    localparam int QUIET_LIMIT  = 500;
    localparam int TAIL_CYCLES  = 40;

    // Request codes the block treats as no operation.
    localparam logic [deq_pkg::REQ_W-1:0] OP_FIRST_UNUSED = 4'd9;
    localparam logic [deq_pkg::REQ_W-1:0] OP_LAST_UNUSED  = 4'd15;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    deq_pkg::deq_req_t req;
    deq_pkg::deq_rsp_t rsp;

    int errors;
    int outstanding;
    int checked;
    int n_issued;
    int n_directed;
    int quiet;
    bit idle_en;
    bit calm_tail;

    double_ended_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    deq_checker #(
        .CAPACITY(CAPACITY)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .errors     (errors),
        .outstanding(outstanding),
        .checked    (checked)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", quiet);
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic deq_pkg::deq_req_t make_req(
        input logic [deq_pkg::REQ_W-1:0]   op,
        input logic [deq_pkg::VALUE_W-1:0] word,
        input logic [deq_pkg::INDEX_W-1:0] index);
        deq_pkg::deq_req_t r;
        r.req_type = op;
        r.value_in = word;
        r.index_in = index;
        return r;
    endfunction

    // Words lean toward the extremes and single set bits, otherwise fully random.
    function automatic logic [deq_pkg::VALUE_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Indexes lean toward zero, all ones and small values.
    function automatic logic [deq_pkg::INDEX_W-1:0] random_index();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return deq_pkg::INDEX_W'($urandom_range(0, 7));
            default: return deq_pkg::INDEX_W'($urandom);
        endcase
    endfunction

    // Mixed request stream; occasional clears keep the fill level modest.
    function automatic deq_pkg::deq_req_t random_request();
        logic [deq_pkg::REQ_W-1:0] op;
        int unsigned               pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            op = deq_pkg::OP_PUSH_BACK;
        else if (pick < 36)
            op = deq_pkg::OP_PUSH_FRONT;
        else if (pick < 48)
            op = deq_pkg::OP_POP_BACK;
        else if (pick < 60)
            op = deq_pkg::OP_POP_FRONT;
        else if (pick < 70)
            op = deq_pkg::OP_READ_AT;
        else if (pick < 76)
            op = deq_pkg::OP_READ_FRONT;
        else if (pick < 82)
            op = deq_pkg::OP_READ_BACK;
        else if (pick < 85)
            op = deq_pkg::OP_CLEAR;
        else if (pick < 95)
            op = deq_pkg::OP_WRITE_AT;
        else
            op = deq_pkg::REQ_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        return make_req(op, random_word(), random_index());
    endfunction

    // Present one request from a falling edge and hold it until the block takes it.
    task automatic issue_request(input deq_pkg::deq_req_t r);
        int gap;
        if (!calm_tail && n_issued % 64 == 0)
            idle_en = ($urandom_range(0, 3) != 0);
        if (idle_en && !calm_tail && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        req = r;
        do
            @(posedge clk);
        while (busy);
        n_issued++;
        @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [deq_pkg::REQ_W-1:0] op;
        int                        pushes;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        n_issued = 0;
        idle_en = 1'b1;
        calm_tail = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: refused requests on an empty queue.
        issue_request(make_req(deq_pkg::OP_READ_FRONT, '1, '0));
        issue_request(make_req(deq_pkg::OP_READ_BACK, '1, '0));
        issue_request(make_req(deq_pkg::OP_POP_BACK, '0, '1));
        issue_request(make_req(deq_pkg::OP_POP_FRONT, '0, '1));
        // Indexed read on an empty queue pushes a zero word; popping the sole entry empties.
        issue_request(make_req(deq_pkg::OP_READ_AT, '1, '1));
        issue_request(make_req(deq_pkg::OP_POP_FRONT, '0, '0));
        issue_request(make_req(deq_pkg::OP_WRITE_AT, '1, 16'h1234));
        issue_request(make_req(deq_pkg::OP_READ_BACK, '0, '0));
        // Both ends, with the front wrapping below slot zero.
        issue_request(make_req(deq_pkg::OP_PUSH_FRONT, '0, '0));
        issue_request(make_req(deq_pkg::OP_PUSH_BACK, '1, '1));
        issue_request(make_req(deq_pkg::OP_PUSH_FRONT, 64'h5555_5555_5555_5555, '0));
        issue_request(make_req(deq_pkg::OP_READ_AT, '0, '1));
        issue_request(make_req(deq_pkg::OP_READ_AT, '1, '0));
        issue_request(make_req(deq_pkg::OP_READ_FRONT, '0, '0));
        issue_request(make_req(deq_pkg::OP_WRITE_AT, 64'hAAAA_AAAA_AAAA_AAAA, 16'd1));
        issue_request(make_req(deq_pkg::OP_READ_AT, '0, 16'd5));
        issue_request(make_req(deq_pkg::OP_POP_BACK, '0, '0));
        issue_request(make_req(deq_pkg::OP_POP_FRONT, '0, '0));
        issue_request(make_req(deq_pkg::OP_CLEAR, '1, '1));
        issue_request(make_req(deq_pkg::OP_READ_BACK, '0, '0));
        issue_request(make_req(OP_FIRST_UNUSED, '1, '1));
        issue_request(make_req(OP_LAST_UNUSED, '1, '1));
        issue_request(make_req(deq_pkg::OP_PUSH_BACK, 64'h8000_0000_0000_0001, '0));
        issue_request(make_req(deq_pkg::OP_POP_BACK, '0, '0));
        n_directed = n_issued;

        // Fill past capacity from both ends, with reads and writes in between.
        issue_request(make_req(deq_pkg::OP_CLEAR, random_word(), random_index()));
        pushes = 0;
        while (pushes < CAPACITY + 6)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: op = deq_pkg::OP_READ_AT;
                    1: op = deq_pkg::OP_WRITE_AT;
                    2: op = deq_pkg::OP_READ_FRONT;
                    default: op = deq_pkg::OP_READ_BACK;
                endcase
            end
            else
            begin
                op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
                pushes++;
            end
            issue_request(make_req(op, random_word(), random_index()));
        end
        issue_request(make_req(deq_pkg::OP_READ_AT, '0, '1));
        issue_request(make_req(deq_pkg::OP_WRITE_AT, '1, '1));
        issue_request(make_req(deq_pkg::OP_READ_AT, '0, '1));
        issue_request(make_req(deq_pkg::OP_READ_BACK, '0, '0));

        // Hold off until the full queue has answered everything.
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);

        // Hover around full, then clear from a large fill level.
        repeat (40)
            issue_request(random_request());
        issue_request(make_req(deq_pkg::OP_CLEAR, random_word(), random_index()));

        // Mixed traffic for the rest, with no idling in the final stretch.
        while (n_issued < n_directed + RANDOM_ITEMS)
        begin
            if (n_issued >= n_directed + RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            issue_request(random_request());
        end

        // Drain and let any stray result show up.
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Summary: %0d requests (%0d directed), %0d results checked, %0d mismatches;",
                 n_issued, n_directed, checked, errors);
        $display("  queue filled past capacity, drained at both ends and cleared at random.");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
